[hw/rtl/ptwa_pkg.sv]
`timescale 1ns / 1ps

package ptwa_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 32;
   localparam logic [19:0] FORGET_RESET = 20'd3000;
   localparam logic [19:0] SILENCE_MAX = 20'hFFFFF;

   localparam logic [1:0] ACT_HEARD = 2'd0;
   localparam logic [1:0] ACT_AGE = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   localparam logic [1:0] MERGE_UPDATED = 2'd0;
   localparam logic [1:0] MERGE_INSERTED = 2'd1;
   localparam logic [1:0] MERGE_DROPPED = 2'd2;
   localparam logic [1:0] MERGE_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] peer_address;
      logic [15:0] peer_port;
      logic [15:0] protocol_version;
      logic [3:0]  player_count;
      logic [3:0]  player_limit;
      logic        game_started;
      logic [15:0] elapsed_ms;
      logic [4:0]  read_index;
   } req_word_type;

   typedef struct packed {
      logic [5:0]  entry_total;
      logic [1:0]  merge_result;
      logic [5:0]  removed_total;
      logic        read_valid;
      logic [31:0] out_address;
      logic [15:0] out_port;
      logic [15:0] out_protocol;
      logic [3:0]  out_players;
      logic [3:0]  out_player_limit;
      logic        out_started;
      logic [19:0] out_silent_ms;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] address;
      logic [15:0] port;
      logic [15:0] protocol;
      logic [3:0]  players;
      logic [3:0]  limit;
      logic        started;
      logic [19:0] silence;
   } entry_type;

endpackage

[hw/rtl/ptwa_ram.sv]
`timescale 1ns / 1ps

module ptwa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/peer_table_with_aging_core.sv]
`timescale 1ns / 1ps

// Channel   Ports                                 Direction  Word
// request   req_valid, req_stall, req_data        in         ptwa_pkg::req_word_type
// response  rsp_valid, rsp_stall, rsp_data        out        ptwa_pkg::rsp_word_type
// config    csr_valid, csr_ready, csr_data        in         forget limit, 20 bits
//
// One word is taken at a time. A heard word or an age tick walks the table through
// the single RAM read port, one entry per cycle. A read passes through the read state
// and then the finish state; an unused action goes straight to the finish state. The
// response register lets the next request enter while a response is still stalled.
// Reset is synchronous and clears the entry count; the table RAM is not cleared.

module peer_table_with_aging_core #(
   parameter int TABLE_ENTRIES = ptwa_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ptwa_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ptwa_pkg::rsp_word_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [19:0]            csr_data
);

   localparam int AW = TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int XW = CW > 6 ? CW : 6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEARD,
      ST_AGE,
      ST_READ,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          kept_ff, kept_in;
   logic [CW-1:0]          removed_ff, removed_in;
   logic                   pend_ff, pend_in;
   logic [AW-1:0]          pend_idx_ff, pend_idx_in;
   logic [19:0]            forget_ff, forget_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ptwa_pkg::rsp_word_type rsp_data_ff, rsp_data_in;
   ptwa_pkg::rsp_word_type res_ff, res_in;
   ptwa_pkg::req_word_type req_ff, req_in;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   ptwa_pkg::entry_type    ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   ptwa_pkg::entry_type    ram_rd_data;

   ptwa_pkg::entry_type    new_entry;
   logic                   key_match;
   logic [20:0]            age_sum;
   logic [19:0]            age_sat;
   logic [XW-1:0]          count_x;
   logic [XW-1:0]          removed_x;
   logic [XW-1:0]          read_idx_x;
   logic                   read_in_range;
   logic                   rsp_free;

   ptwa_ram #(
      .WIDTH($bits(ptwa_pkg::entry_type)),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en(ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assign count_x = XW'(count_ff);
   assign removed_x = XW'(removed_ff);
   assign read_idx_x = XW'(req_data.read_index);
   assign read_in_range = (read_idx_x < count_x);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign key_match = pend_ff && (ram_rd_data.address == req_ff.peer_address)
                      && (ram_rd_data.port == req_ff.peer_port);
   assign age_sum = {1'b0, ram_rd_data.silence} + {5'd0, req_ff.elapsed_ms};
   assign age_sat = age_sum[20] ? ptwa_pkg::SILENCE_MAX : age_sum[19:0];

   always_comb begin
      new_entry.address = req_ff.peer_address;
      new_entry.port = req_ff.peer_port;
      new_entry.protocol = req_ff.protocol_version;
      new_entry.players = req_ff.player_count;
      new_entry.limit = req_ff.player_limit;
      new_entry.started = req_ff.game_started;
      new_entry.silence = 20'd0;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      kept_in = kept_ff;
      removed_in = removed_ff;
      pend_in = pend_ff;
      pend_idx_in = pend_idx_ff;
      forget_in = forget_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      res_in = res_ff;
      req_in = req_ff;
      ram_wr_en = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = new_entry;
      ram_rd_en = 1'b0;
      ram_rd_addr = '0;

      if (csr_valid) begin
         forget_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               idx_in = '0;
               kept_in = '0;
               removed_in = '0;
               pend_in = 1'b0;
               res_in = '0;
               res_in.merge_result = ptwa_pkg::MERGE_NONE;
               case (req_data.action)
                  ptwa_pkg::ACT_HEARD: begin
                     state_in = ST_HEARD;
                  end
                  ptwa_pkg::ACT_AGE: begin
                     state_in = ST_AGE;
                  end
                  ptwa_pkg::ACT_READ: begin
                     if (read_in_range) begin
                        ram_rd_en = 1'b1;
                        ram_rd_addr = read_idx_x[AW-1:0];
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_HEARD: begin
            if (key_match) begin
               ram_wr_en = 1'b1;
               ram_wr_addr = pend_idx_ff;
               pend_in = 1'b0;
               res_in.merge_result = ptwa_pkg::MERGE_UPDATED;
               state_in = ST_FINISH;
            end else if (idx_ff < count_ff) begin
               ram_rd_en = 1'b1;
               ram_rd_addr = idx_ff[AW-1:0];
               pend_in = 1'b1;
               pend_idx_in = idx_ff[AW-1:0];
               idx_in = idx_ff + CW'(1);
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               if (count_x < XW'(TABLE_ENTRIES)) begin
                  ram_wr_en = 1'b1;
                  ram_wr_addr = count_ff[AW-1:0];
                  count_in = count_ff + CW'(1);
                  res_in.merge_result = ptwa_pkg::MERGE_INSERTED;
               end else begin
                  res_in.merge_result = ptwa_pkg::MERGE_DROPPED;
               end
               state_in = ST_FINISH;
            end
         end
         ST_AGE: begin
            if (pend_ff) begin
               if (age_sat > forget_ff) begin
                  removed_in = removed_ff + CW'(1);
               end else begin
                  ram_wr_en = 1'b1;
                  ram_wr_addr = kept_ff[AW-1:0];
                  ram_wr_data = ram_rd_data;
                  ram_wr_data.silence = age_sat;
                  kept_in = kept_ff + CW'(1);
               end
            end
            if (idx_ff < count_ff) begin
               ram_rd_en = 1'b1;
               ram_rd_addr = idx_ff[AW-1:0];
               pend_in = 1'b1;
               pend_idx_in = idx_ff[AW-1:0];
               idx_in = idx_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = kept_ff;
                  res_in.removed_total = removed_x[5:0];
                  state_in = ST_FINISH;
               end
            end
         end
         ST_READ: begin
            res_in.read_valid = 1'b1;
            res_in.out_address = ram_rd_data.address;
            res_in.out_port = ram_rd_data.port;
            res_in.out_protocol = ram_rd_data.protocol;
            res_in.out_players = ram_rd_data.players;
            res_in.out_player_limit = ram_rd_data.limit;
            res_in.out_started = ram_rd_data.started;
            res_in.out_silent_ms = ram_rd_data.silence;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_data_in = res_ff;
               rsp_data_in.entry_total = count_x[5:0];
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      res_ff <= res_in;
      req_ff <= req_in;
      idx_ff <= idx_in;
      kept_ff <= kept_in;
      removed_ff <= removed_in;
      pend_idx_ff <= pend_idx_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff <= 1'b0;
         forget_ff <= ptwa_pkg::FORGET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff <= pend_in;
         forget_ff <= forget_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
